### hw/rtl/sad_pkg.sv
// Shared constants, tangent midpoint table, types and state codes for the slope angle block.
package sad_pkg;

    // Field and table sizes.
    localparam int COORD_W       = 16;
    localparam int FRAC_BITS     = 16;
    localparam int TABLE_ENTRIES = 90;
    localparam int NUM_MIDS      = TABLE_ENTRIES - 1;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int MAG_W         = COORD_W;
    localparam int MID_W         = FRAC_BITS + 6;
    localparam int PROD_W        = MID_W + MAG_W;
    localparam int STEPS         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = STEPS;
    localparam int IDX_W         = $clog2(NUM_MIDS);
    localparam int ANGLE_W       = 8;
    localparam int STEEP_MUL     = 57;
    localparam int STEEP_W       = MAG_W + 6;
    localparam int ANGLE_MAX     = 90;
    localparam int TAN_SCALE     = 20000;

    // Tangent of 0..89 degrees in units of 1/10000.
    localparam int unsigned TAN_E4 [TABLE_ENTRIES] = '{
        0, 175, 349, 524, 699, 875, 1051, 1228, 1405, 1584,
        1763, 1944, 2125, 2309, 2493, 2679, 2867, 3057, 3249, 3443,
        3639, 3838, 4040, 4244, 4452, 4663, 4877, 5095, 5317, 5543,
        5773, 6008, 6248, 6493, 6744, 7001, 7265, 7535, 7812, 8097,
        8390, 8692, 9003, 9324, 9656, 10000, 10354, 10722, 11105, 11502,
        11916, 12347, 12798, 13269, 13762, 14279, 14823, 15396, 16001, 16640,
        17317, 18037, 18804, 19622, 20499, 21440, 22455, 23553, 24745, 26044,
        27467, 29033, 30767, 32698, 34862, 37306, 40091, 43295, 47023, 51418,
        56679, 63095, 71099, 81372, 95045, 114157, 142780, 190404, 285437, 569168
    };

    typedef logic [MID_W-1:0] t_mid;
    typedef t_mid t_mid_table [NUM_MIDS];

    // Midpoint of neighboring tangents in fixed point, rounded half up.
    function automatic t_mid_table build_mids();
        t_mid_table     tbl;
        longint unsigned s;
        int             k;
        for (k = 0; k < NUM_MIDS; k++) begin
            s      = longint'(TAN_E4[k]) + longint'(TAN_E4[k+1]);
            tbl[k] = MID_W'(((s << FRAC_BITS) + TAN_SCALE / 2) / TAN_SCALE);
        end
        return tbl;
    endfunction

    localparam t_mid_table MID_TABLE = build_mids();

    // Request to the shared multiply-compare unit.
    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [IDX_W-1:0] idx;
    } t_cmp_req;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SEARCH
    } t_state;

endpackage

### hw/rtl/slope_angle_degrees.sv
// A request passes through the setup state, then the search; vertical and near-vertical lines end in setup.
// The block takes no new request until it has delivered its result; busy stays high meanwhile.
// The work is a setup state plus a 7-step binary search through one multiply-compare unit.
// The result shows for one cycle on o_valid; the receiver cannot stall it.
// Reset is synchronous and active low; it clears the sequencer and the strobe only.
// Top level: angle of the line through two points, in whole degrees.
module slope_angle_degrees (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sad_pkg::COORD_W-1:0]  i_first_x,
    input  logic signed [sad_pkg::COORD_W-1:0]  i_first_y,
    input  logic signed [sad_pkg::COORD_W-1:0]  i_second_x,
    input  logic signed [sad_pkg::COORD_W-1:0]  i_second_y,
    output logic                                o_valid,
    output logic signed [sad_pkg::ANGLE_W-1:0]  o_angle_degrees
);

    sad_pkg::t_state r_state, n_state;

    logic signed [sad_pkg::DIFF_W-1:0] r_dx, n_dx;
    logic signed [sad_pkg::DIFF_W-1:0] r_dy, n_dy;
    logic [sad_pkg::MAG_W-1:0]         r_ax, n_ax;
    logic [sad_pkg::MAG_W-1:0]         r_ay, n_ay;
    logic                              r_neg, n_neg;
    logic [sad_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [sad_pkg::CNT_W-1:0]         r_bit, n_bit;
    logic                              r_valid, n_valid;
    logic signed [sad_pkg::ANGLE_W-1:0] r_angle, n_angle;

    logic [sad_pkg::DIFF_W-1:0]  dx_abs;
    logic [sad_pkg::DIFF_W-1:0]  dy_abs;
    logic [sad_pkg::STEEP_W-1:0] steep_lim;
    logic                        steep;
    logic [sad_pkg::CNT_W:0]     cand;
    logic                        in_range;
    logic                        take;
    sad_pkg::t_cmp_req           cmp_req;
    logic                        cmp_gt;

    sad_cmp u_cmp (
        .i_req (cmp_req),
        .o_gt  (cmp_gt)
    );

    // Search candidate: next count to test, valid while it names a midpoint.
    always_comb begin
        cand     = {1'b0, r_cnt} + {1'b0, r_bit};
        in_range = (cand != '0) && (cand <= (sad_pkg::CNT_W+1)'(sad_pkg::NUM_MIDS));
        cmp_req.ax  = r_ax;
        cmp_req.ay  = r_ay;
        cmp_req.idx = in_range ? sad_pkg::IDX_W'(cand - 1'b1) : '0;
        take     = in_range && cmp_gt;
    end

    // Magnitudes and the steep-slope test for the setup cycle.
    always_comb begin
        dx_abs    = r_dx[sad_pkg::DIFF_W-1] ? sad_pkg::DIFF_W'(-r_dx) : sad_pkg::DIFF_W'(r_dx);
        dy_abs    = r_dy[sad_pkg::DIFF_W-1] ? sad_pkg::DIFF_W'(-r_dy) : sad_pkg::DIFF_W'(r_dy);
        steep_lim = sad_pkg::STEEP_W'(sad_pkg::STEEP_MUL) * sad_pkg::STEEP_W'(dx_abs);
        steep     = sad_pkg::STEEP_W'(dy_abs) >= steep_lim;
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state = r_state;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_bit   = r_bit;
        n_valid = 1'b0;
        n_angle = r_angle;
        case (r_state)
            sad_pkg::ST_IDLE: begin
                if (start) begin
                    n_dx    = sad_pkg::DIFF_W'(i_second_x) - sad_pkg::DIFF_W'(i_first_x);
                    n_dy    = sad_pkg::DIFF_W'(i_second_y) - sad_pkg::DIFF_W'(i_first_y);
                    n_state = sad_pkg::ST_SETUP;
                end
            end
            sad_pkg::ST_SETUP: begin
                n_ax  = sad_pkg::MAG_W'(dx_abs);
                n_ay  = sad_pkg::MAG_W'(dy_abs);
                n_neg = (r_dx[sad_pkg::DIFF_W-1] != r_dy[sad_pkg::DIFF_W-1])
                        && (r_dx != '0) && (r_dy != '0);
                n_cnt = '0;
                n_bit = sad_pkg::CNT_W'(1) << (sad_pkg::STEPS - 1);
                if (r_dx == '0) begin
                    // Vertical line: sign follows dy alone.
                    n_angle = r_dy[sad_pkg::DIFF_W-1] ? sad_pkg::ANGLE_W'(-sad_pkg::ANGLE_MAX)
                                                      : sad_pkg::ANGLE_W'(sad_pkg::ANGLE_MAX);
                    n_valid = 1'b1;
                    n_state = sad_pkg::ST_IDLE;
                end else if (steep) begin
                    n_angle = n_neg ? sad_pkg::ANGLE_W'(-sad_pkg::ANGLE_MAX)
                                    : sad_pkg::ANGLE_W'(sad_pkg::ANGLE_MAX);
                    n_valid = 1'b1;
                    n_state = sad_pkg::ST_IDLE;
                end else begin
                    n_state = sad_pkg::ST_SEARCH;
                end
            end
            sad_pkg::ST_SEARCH: begin
                // One binary-search step: keep the candidate if its midpoint lies below.
                if (take) begin
                    n_cnt = sad_pkg::CNT_W'(cand);
                end
                n_bit = r_bit >> 1;
                if (r_bit[0]) begin
                    n_angle = r_neg ? sad_pkg::ANGLE_W'(-$signed({1'b0, n_cnt}))
                                    : sad_pkg::ANGLE_W'({1'b0, n_cnt});
                    n_valid = 1'b1;
                    n_state = sad_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sad_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sad_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_ax    <= n_ax;
        r_ay    <= n_ay;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_bit   <= n_bit;
        r_angle <= n_angle;
    end

    assign busy            = (r_state != sad_pkg::ST_IDLE);
    assign o_valid         = r_valid;
    assign o_angle_degrees = r_angle;

endmodule

### hw/rtl/sad_cmp.sv
// Shared multiply-compare unit: tests |dy| << FRAC_BITS against midpoint times |dx|.
module sad_cmp (
    input  sad_pkg::t_cmp_req i_req,
    output logic              o_gt
);

    logic [sad_pkg::MID_W-1:0]  mid;
    logic [sad_pkg::PROD_W-1:0] prod;
    logic [sad_pkg::PROD_W-1:0] lhs;

    // Table lookup, one multiply and one compare.
    always_comb begin
        mid  = sad_pkg::MID_TABLE[i_req.idx];
        prod = sad_pkg::PROD_W'(mid) * sad_pkg::PROD_W'(i_req.ax);
        lhs  = sad_pkg::PROD_W'(i_req.ay) << sad_pkg::FRAC_BITS;
        o_gt = lhs > prod;
    end

endmodule

### hw/rtl/sad_checker.sv
// Port-level assertions for the slope angle block and their bind.
module sad_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic signed [sad_pkg::ANGLE_W-1:0] o_angle_degrees
);

    // A result stays within the angle range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle_degrees >= -sad_pkg::ANGLE_MAX)
                 && (o_angle_degrees <= sad_pkg::ANGLE_MAX))
        else $error("angle out of range");

    // An accepted request makes the block busy.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // The block frees up only by delivering a result.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy fell without a result");

    // The strobe lasts one cycle and is never seen while busy.
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy ##1 !o_valid)
        else $error("result strobe malformed");

endmodule

bind slope_angle_degrees sad_checker u_sad_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_angle_degrees (o_angle_degrees)
);
